/* design/great_circle_range_bearing_top_assert.svh */
// Assertion macros for the range and bearing block.
// Each macro expects clk and rst_n in scope.
`ifndef GREAT_CIRCLE_RANGE_BEARING_TOP_ASSERT_SVH
`define GREAT_CIRCLE_RANGE_BEARING_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define GCRB_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define GCRB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/gcrb_pkg.sv */
`default_nettype none

package gcrb_pkg;

  // Datapath widths
  localparam int BAM_W  = 32;
  localparam int CW     = 33;   // rotation CORDIC x, y, z
  localparam int MW     = 34;   // scaled products
  localparam int VW     = 35;   // vectoring CORDIC x, y
  localparam int ROOT_W = 31;   // square root result
  localparam int SQ_W   = 62;   // square root remainder
  localparam int RAD_W  = 23;
  localparam int DIST_W = 25;
  localparam int BEAR_W = 16;

  typedef logic [BAM_W-1:0]         bam_t;
  typedef logic signed [CW-1:0]     trig_t;
  typedef logic signed [MW-1:0]     prd_t;
  typedef logic signed [VW-1:0]     vec_t;
  typedef logic [ROOT_W-1:0]        root_t;

  // Vector carried alongside the square root pipeline
  typedef struct packed {
    vec_t y;
    vec_t x;
  } vpair_t;

  // CORDIC gain compensation, Q1.30
  localparam trig_t GAIN_Q30 = 33'sd652032874;

  // atan(2^-i) as binary angle, rounded
  localparam logic [30:0] ATAN_BAM [32] = '{
    31'd536870912, 31'd316933406, 31'd167458907, 31'd85004756,
    31'd42667331,  31'd21354465,  31'd10679838,  31'd5340245,
    31'd2670163,   31'd1335087,   31'd667544,    31'd333772,
    31'd166886,    31'd83443,     31'd41722,     31'd20861,
    31'd10430,     31'd5215,      31'd2608,      31'd1304,
    31'd652,       31'd326,       31'd163,       31'd81,
    31'd41,        31'd20,        31'd10,        31'd5,
    31'd3,         31'd1,         31'd1,         31'd0
  };

  localparam logic [RAD_W-1:0]  RADIUS_RST = 23'd6371000;
  localparam logic [30:0]       PI_Q29     = 31'd1686629713;
  localparam logic [DIST_W-1:0] DIST_MAX   = 25'd20500000;
  localparam logic [BEAR_W-1:0] DEG_SCALE  = 16'd36000;
  localparam logic [30:0]       ONE_Q30    = 31'h4000_0000;

endpackage

`default_nettype wire

/* design/gcrb_to_bam.sv */
`default_nettype none

module gcrb_to_bam import gcrb_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_vld,
  input  logic signed [31:0] coord,     // 1e-7 degree
  output logic               out_vld,
  output bam_t               bam
);

  // q = floor(mag * 2^28 / DIV) via reciprocal, then one correction step
  localparam logic [31:0] RECIP = 32'd2562047788;   // floor(2^59 / DIV)
  localparam logic [27:0] DIV   = 28'd225000000;

  logic [3:0]  vld_r;
  logic [31:0] mag1_r, mag2_r, mag3_r;
  logic        neg1_r, neg2_r, neg3_r;
  logic [31:0] est2_r, est3_r;
  logic [59:0] ed3_r;
  bam_t        bam_r;

  logic [63:0] est_prod;
  logic [59:0] rem;
  logic [31:0] q;

  // Valid bits follow the payload
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[2:0], in_vld};
    end
  end

  always_comb begin
    est_prod = 64'(mag1_r) * 64'(RECIP);
    rem      = {mag3_r, 28'b0} - ed3_r;
    q        = est3_r + 32'(rem >= 60'(DIV));
  end

  // Magnitude, reciprocal estimate, back product, correct and restore sign
  always_ff @(posedge clk) begin
    if (en) begin
      neg1_r <= coord[31];
      mag1_r <= coord[31] ? 32'(-coord) : 32'(coord);
      neg2_r <= neg1_r;
      mag2_r <= mag1_r;
      est2_r <= est_prod[62:31];
      neg3_r <= neg2_r;
      mag3_r <= mag2_r;
      est3_r <= est2_r;
      ed3_r  <= 60'(est2_r) * 60'(DIV);
      bam_r  <= neg3_r ? (32'd0 - q) : q;
    end
  end

  assign out_vld = vld_r[3];
  assign bam     = bam_r;

endmodule

`default_nettype wire

/* design/gcrb_sincos.sv */
`default_nettype none

module gcrb_sincos import gcrb_pkg::*; #(
  parameter int STEPS = 24
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  en,
  input  logic  in_vld,
  input  bam_t  angle,
  output logic  out_vld,
  output trig_t cos_q30,
  output trig_t sin_q30
);

  logic [STEPS+1:0] vld_r;
  trig_t            x_r [STEPS+1];
  trig_t            y_r [STEPS+1];
  trig_t            z_r [STEPS+1];
  logic [STEPS:0]   flip_r;
  trig_t            cos_r, sin_r;

  bam_t a_rot, a_adj;
  logic flip0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[STEPS:0], in_vld};
    end
  end

  // Fold the angle into the right half plane
  always_comb begin
    a_rot = angle + 32'h4000_0000;
    flip0 = a_rot[31];
    a_adj = flip0 ? (angle - 32'h8000_0000) : angle;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]    <= GAIN_Q30;
      y_r[0]    <= '0;
      z_r[0]    <= trig_t'({a_adj[31], a_adj});
      flip_r[0] <= flip0;
    end
  end

  // One rotation per stage
  for (genvar i = 0; i < STEPS; i++) begin : g_rot
    trig_t dx, dy, da;
    assign dx = x_r[i] >>> i;
    assign dy = y_r[i] >>> i;
    assign da = trig_t'({2'b00, ATAN_BAM[i]});

    always_ff @(posedge clk) begin
      if (en) begin
        if (!z_r[i][CW-1]) begin
          x_r[i+1] <= x_r[i] - dy;
          y_r[i+1] <= y_r[i] + dx;
          z_r[i+1] <= z_r[i] - da;
        end else begin
          x_r[i+1] <= x_r[i] + dy;
          y_r[i+1] <= y_r[i] - dx;
          z_r[i+1] <= z_r[i] + da;
        end
        flip_r[i+1] <= flip_r[i];
      end
    end
  end

  // Undo the fold
  always_ff @(posedge clk) begin
    if (en) begin
      cos_r <= flip_r[STEPS] ? -x_r[STEPS] : x_r[STEPS];
      sin_r <= flip_r[STEPS] ? -y_r[STEPS] : y_r[STEPS];
    end
  end

  assign out_vld = vld_r[STEPS+1];
  assign cos_q30 = cos_r;
  assign sin_q30 = sin_r;

endmodule

`default_nettype wire

/* design/gcrb_isqrt.sv */
`default_nettype none

module gcrb_isqrt import gcrb_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_vld,
  input  logic [SQ_W-2:0]   n_a,
  input  logic [SQ_W-2:0]   n_b,
  input  vpair_t            side_in,
  output logic              out_vld,
  output root_t             root_a,
  output root_t             root_b,
  output vpair_t            side_out
);

  logic [ROOT_W:0] vld_r;
  vpair_t          side_r [ROOT_W+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[ROOT_W-1:0], in_vld};
    end
  end

  // Carry the vector alongside the roots
  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= side_in;
      for (int j = 0; j < ROOT_W; j++) begin
        side_r[j+1] <= side_r[j];
      end
    end
  end

  // Two independent lanes, one result bit per stage, most significant first
  for (genvar l = 0; l < 2; l++) begin : g_lane
    logic [SQ_W-1:0] d_r [ROOT_W+1];
    root_t           q_r [ROOT_W+1];

    always_ff @(posedge clk) begin
      if (en) begin
        d_r[0] <= (l == 0) ? {1'b0, n_a} : {1'b0, n_b};
        q_r[0] <= '0;
      end
    end

    for (genvar j = 0; j < ROOT_W; j++) begin : g_bit
      localparam int K = ROOT_W - 1 - j;
      logic [SQ_W-1:0] trial;
      assign trial = (SQ_W'(q_r[j]) << (K + 1)) + (SQ_W'(1) << (2 * K));

      always_ff @(posedge clk) begin
        if (en) begin
          if (d_r[j] >= trial) begin
            d_r[j+1] <= d_r[j] - trial;
            q_r[j+1] <= q_r[j] | (ROOT_W'(1) << K);
          end else begin
            d_r[j+1] <= d_r[j];
            q_r[j+1] <= q_r[j];
          end
        end
      end
    end
  end

  assign out_vld  = vld_r[ROOT_W];
  assign root_a   = g_lane[0].q_r[ROOT_W];
  assign root_b   = g_lane[1].q_r[ROOT_W];
  assign side_out = side_r[ROOT_W];

endmodule

`default_nettype wire

/* design/gcrb_vector.sv */
`default_nettype none

module gcrb_vector import gcrb_pkg::*; #(
  parameter int STEPS = 24
) (
  input  logic clk,
  input  logic rst_n,
  input  logic en,
  input  logic in_vld,
  input  vec_t vy,
  input  vec_t vx,
  output logic out_vld,
  output bam_t angle
);

  logic [STEPS+1:0] vld_r;
  vec_t             x_r [STEPS+1];
  vec_t             y_r [STEPS+1];
  trig_t            z_r [STEPS+1];
  logic [STEPS:0]   base_r;
  logic [STEPS:0]   zero_r;
  bam_t             angle_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[STEPS:0], in_vld};
    end
  end

  // Move the vector into the right half plane, flag the zero vector
  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]    <= vx[VW-1] ? -vx : vx;
      y_r[0]    <= vx[VW-1] ? -vy : vy;
      z_r[0]    <= '0;
      base_r[0] <= vx[VW-1];
      zero_r[0] <= (vx == '0) && (vy == '0);
    end
  end

  // One micro-rotation toward the x axis per stage
  for (genvar i = 0; i < STEPS; i++) begin : g_vec
    vec_t  dx, dy;
    trig_t da;
    assign dx = x_r[i] >>> i;
    assign dy = y_r[i] >>> i;
    assign da = trig_t'({2'b00, ATAN_BAM[i]});

    always_ff @(posedge clk) begin
      if (en) begin
        if (!y_r[i][VW-1]) begin
          x_r[i+1] <= x_r[i] + dy;
          y_r[i+1] <= y_r[i] - dx;
          z_r[i+1] <= z_r[i] + da;
        end else begin
          x_r[i+1] <= x_r[i] - dy;
          y_r[i+1] <= y_r[i] + dx;
          z_r[i+1] <= z_r[i] - da;
        end
        base_r[i+1] <= base_r[i];
        zero_r[i+1] <= zero_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      angle_r <= zero_r[STEPS] ? '0 : ({base_r[STEPS], 31'b0} + z_r[STEPS][BAM_W-1:0]);
    end
  end

  assign out_vld = vld_r[STEPS+1];
  assign angle   = angle_r;

endmodule

`default_nettype wire

/* design/great_circle_range_bearing_top.sv */
// Great-circle range and initial bearing. Each request carries an own and a
// target position (latitude, longitude in 1e-7 degree); the result is the
// haversine distance in whole meters (truncated, saturated at 20500000) and
// the initial true bearing in 0.01 degree (0..35999). One request enters per
// clock while in_tready is high, passing through the two CORDIC chains and
// the square root pipeline. A full stall is absorbed by a one-entry skid
// stage behind the output register. The radius register is written through
// cfg_we / cfg_wdata and resets to 6371000 m; write it only when no request
// is in flight.
`default_nettype none

`include "great_circle_range_bearing_top_assert.svh"

module great_circle_range_bearing_top import gcrb_pkg::*; #(
  parameter int CORDIC_STEPS = 24    // 12 .. 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [RAD_W-1:0]   cfg_wdata,   // earth_radius_m
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [127:0]       in_tdata,    // own_lat[30:0], own_lon[62:31],
                                          // target_lat[93:63], target_lon[125:94]
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [47:0]        out_tdata    // distance_m[24:0], bearing_cdeg[40:25]
);

  logic en;

  // Radius register
  logic [RAD_W-1:0] radius_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= RADIUS_RST;
    end else if (cfg_we) begin
      radius_r <= cfg_wdata;
    end
  end

  // Coordinates to binary angles
  logic [3:0] bam_vld;
  bam_t       bam [4];
  logic signed [31:0] coord [4];

  assign coord[0] = 32'(signed'(in_tdata[30:0]));
  assign coord[1] = signed'(in_tdata[62:31]);
  assign coord[2] = 32'(signed'(in_tdata[93:63]));
  assign coord[3] = signed'(in_tdata[125:94]);

  for (genvar c = 0; c < 4; c++) begin : g_bam
    gcrb_to_bam u_to_bam (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .in_vld  (in_tvalid),
      .coord   (coord[c]),
      .out_vld (bam_vld[c]),
      .bam     (bam[c])
    );
  end

  // Differences and half angles
  logic ang_vld_r;
  bam_t b1_r, b3_r, dlon_r, hlat_r, hlon_r;
  bam_t dlat, dlon;

  assign dlat = bam[2] - bam[0];
  assign dlon = bam[3] - bam[1];

  always_ff @(posedge clk) begin
    if (en) begin
      b1_r   <= bam[0];
      b3_r   <= bam[2];
      dlon_r <= dlon;
      hlat_r <= {dlat[31], dlat[31:1]};
      hlon_r <= {dlon[31], dlon[31:1]};
    end
  end

  // Five sine / cosine pipelines in lockstep
  bam_t        sc_ang [5];
  logic [4:0]  sc_vld;
  trig_t       sc_cos [5];
  trig_t       sc_sin [5];

  assign sc_ang[0] = b1_r;
  assign sc_ang[1] = b3_r;
  assign sc_ang[2] = dlon_r;
  assign sc_ang[3] = hlat_r;
  assign sc_ang[4] = hlon_r;

  for (genvar s = 0; s < 5; s++) begin : g_sc
    gcrb_sincos #(.STEPS(CORDIC_STEPS)) u_sincos (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .in_vld  (ang_vld_r),
      .angle   (sc_ang[s]),
      .out_vld (sc_vld[s]),
      .cos_q30 (sc_cos[s]),
      .sin_q30 (sc_sin[s])
    );
  end

  // First products
  logic m1_vld_r;
  prd_t p1_r, p2_r, p3_r, q1_r, q2_r, by1_r;
  trig_t cd1_r;
  logic signed [2*CW-1:0] pp1, pp2, pp3, pq1, pq2, pby;

  always_comb begin
    pp1 = sc_sin[3] * sc_sin[3];
    pp2 = sc_cos[0] * sc_cos[1];
    pp3 = sc_sin[4] * sc_sin[4];
    pq1 = sc_cos[0] * sc_sin[1];
    pq2 = sc_sin[0] * sc_cos[1];
    pby = sc_sin[2] * sc_cos[1];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_r  <= MW'(pp1 >>> 30);
      p2_r  <= MW'(pp2 >>> 30);
      p3_r  <= MW'(pp3 >>> 30);
      q1_r  <= MW'(pq1 >>> 30);
      q2_r  <= MW'(pq2 >>> 30);
      by1_r <= MW'(pby >>> 30);
      cd1_r <= sc_cos[2];
    end
  end

  // Second products: haversine term and bearing x
  logic m2_vld_r;
  vec_t a2_r, bx2_r, by2_r;
  logic signed [2*MW-1:0]    pa;
  logic signed [MW+CW-1:0]   pbx;

  always_comb begin
    pa  = p2_r * p3_r;
    pbx = q2_r * cd1_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a2_r  <= VW'(p1_r) + VW'(pa >>> 30);
      bx2_r <= VW'(q1_r) - VW'(pbx >>> 30);
      by2_r <= VW'(by1_r);
    end
  end

  // Clamp the haversine term, form both radicands
  logic [30:0] a_c;
  logic [30:0] a_rest;

  always_comb begin
    if (a2_r[VW-1]) begin
      a_c = '0;
    end else if (a2_r > VW'(ONE_Q30)) begin
      a_c = ONE_Q30;
    end else begin
      a_c = a2_r[30:0];
    end
    a_rest = ONE_Q30 - a_c;
  end

  logic   sq_vld;
  root_t  root_a, root_b;
  vpair_t bvec;

  gcrb_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (m2_vld_r),
    .n_a      ({a_c, 30'b0}),
    .n_b      ({a_rest, 30'b0}),
    .side_in  (vpair_t'{y: by2_r, x: bx2_r}),
    .out_vld  (sq_vld),
    .root_a   (root_a),
    .root_b   (root_b),
    .side_out (bvec)
  );

  // Half central angle and bearing angle
  logic vec_vld, vec_vld_b;
  bam_t hz, bz;

  gcrb_vector #(.STEPS(CORDIC_STEPS)) u_vec_dist (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (sq_vld),
    .vy      (vec_t'({4'b0, root_a})),
    .vx      (vec_t'({4'b0, root_b})),
    .out_vld (vec_vld),
    .angle   (hz)
  );

  gcrb_vector #(.STEPS(CORDIC_STEPS)) u_vec_bear (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (sq_vld),
    .vy      (bvec.y),
    .vx      (bvec.x),
    .out_vld (vec_vld_b),
    .angle   (bz)
  );

  // Scale to meters and hundredths of a degree
  logic        d1_vld_r, d2_vld_r, d3_vld_r;
  logic [30:0] h;
  logic [53:0] t1_r;
  logic [47:0] bp;
  logic [BEAR_W-1:0] bear1_r, bear2_r, bear3_r;
  logic [55:0] u1_r;
  logic [30:0] u2_r;
  logic [59:0] u2p;
  logic [56:0] dsum;
  logic [26:0] dq;
  logic [DIST_W-1:0] dist3_r;

  always_comb begin
    if (hz[31]) begin
      h = '0;
    end else if (hz[30:0] > ONE_Q30) begin
      h = ONE_Q30;
    end else begin
      h = hz[30:0];
    end
    bp   = 48'(bz) * 48'(DEG_SCALE);
    u2p  = 60'(t1_r[28:0]) * 60'(PI_Q29);
    dsum = 57'(u1_r) + 57'(u2_r);
    dq   = dsum[56:30];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t1_r    <= 54'(radius_r) * 54'(h);
      bear1_r <= bp[47:32];
      u1_r    <= 56'(t1_r[53:29]) * 56'(PI_Q29);
      u2_r    <= u2p[59:29];
      bear2_r <= bear1_r;
      dist3_r <= (dq > 27'(DIST_MAX)) ? DIST_MAX : dq[DIST_W-1:0];
      bear3_r <= bear2_r;
    end
  end

  // Valid bits of the stages kept here
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ang_vld_r <= 1'b0;
      m1_vld_r  <= 1'b0;
      m2_vld_r  <= 1'b0;
      d1_vld_r  <= 1'b0;
      d2_vld_r  <= 1'b0;
      d3_vld_r  <= 1'b0;
    end else if (en) begin
      ang_vld_r <= bam_vld[0];
      m1_vld_r  <= sc_vld[0];
      m2_vld_r  <= m1_vld_r;
      d1_vld_r  <= vec_vld;
      d2_vld_r  <= d1_vld_r;
      d3_vld_r  <= d2_vld_r;
    end
  end

  // Output register with a one-entry skid stage
  logic              out_vld_r, out_vld_nxt;
  logic              skid_vld_r, skid_vld_nxt;
  logic              out_load_d3, out_load_skid, skid_load;
  logic [DIST_W-1:0] out_dist_r, skid_dist_r;
  logic [BEAR_W-1:0] out_bear_r, skid_bear_r;

  assign en        = !skid_vld_r;
  assign in_tready = en;

  always_comb begin
    out_vld_nxt   = out_vld_r;
    skid_vld_nxt  = skid_vld_r;
    out_load_d3   = 1'b0;
    out_load_skid = 1'b0;
    skid_load     = 1'b0;
    priority if (skid_vld_r) begin
      if (out_tready) begin
        out_load_skid = 1'b1;
        skid_vld_nxt  = 1'b0;
      end
    end else if (!out_vld_r || out_tready) begin
      out_vld_nxt = d3_vld_r;
      out_load_d3 = d3_vld_r;
    end else if (d3_vld_r) begin
      skid_vld_nxt = 1'b1;
      skid_load    = 1'b1;
    end else begin
      skid_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      out_vld_r  <= out_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load_skid) begin
      out_dist_r <= skid_dist_r;
      out_bear_r <= skid_bear_r;
    end else if (out_load_d3) begin
      out_dist_r <= dist3_r;
      out_bear_r <= bear3_r;
    end
    if (skid_load) begin
      skid_dist_r <= dist3_r;
      skid_bear_r <= bear3_r;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {7'b0, out_bear_r, out_dist_r};

  // Parallel lanes carry the same valid pattern
  logic lanes_even;

  assign lanes_even = (bam_vld == {4{bam_vld[0]}}) && (sc_vld == {5{sc_vld[0]}}) &&
                      (vec_vld == vec_vld_b);

  // Checks
  `GCRB_ASSERT_SAME(a_skid_behind_out, skid_vld_r, out_vld_r, "skid full with output empty")
  `GCRB_ASSERT_NEXT(a_stall_to_skid, out_vld_r && !out_tready && !skid_vld_r && d3_vld_r, skid_vld_r, "stalled request not caught in skid")
  `GCRB_ASSERT_NEXT(a_pipe_hold, !en && d3_vld_r, d3_vld_r, "last stage dropped a request during stall")
  `GCRB_ASSERT_SAME(a_bear_range, out_vld_r, out_bear_r < DEG_SCALE, "bearing out of range")
  `GCRB_ASSERT_SAME(a_dist_range, out_vld_r, out_dist_r <= DIST_MAX, "distance above saturation")
  `GCRB_ASSERT_SAME(a_lanes_even, 1'b1, lanes_even, "parallel lanes out of step")

endmodule

`default_nettype wire
